>>> hdl/ocp_pkg.sv
// orbit camera position: shared constants, trig request struct and sine table builder
// no dependencies; used by ocp_trig and orbit_camera_position
package ocp_pkg;

  // angles in half-degree units
  localparam int TURN          = 720;
  localparam int HALF_TURN     = 360;
  localparam int QUARTER_TURN  = 180;
  localparam int THREE_QUARTER = 540;
  localparam int PITCH_LIMIT   = 178;
  localparam int ELEV_OFFSET   = 540;
  localparam int ORBIT_RESET   = 360;

  // distance register reset, 3.0 in Q8.8
  localparam logic [15:0] DIST_RESET = 16'd768;

  // trig fraction bits default
  localparam int TRIG_FRACTION_BITS = 15;

  // quarter-wave sine table, Q1.30 series sums before final rounding
  localparam int SIN_ROM_DEPTH = 181;
  localparam int SIN_ROM_W     = 31;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] SERIES_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  typedef logic [SIN_ROM_W-1:0] sin_rom_t [SIN_ROM_DEPTH];

  // request to the trig unit
  typedef struct packed {
    logic [9:0] angle;    // 0..719
    logic       cos_sel;  // cosine instead of sine
    logic       negate;   // negate the result
  } trig_req_t;

  // series evaluation, run at elaboration only
  function automatic sin_rom_t sin_rom_build();
    sin_rom_t           rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int q = 0; q < SIN_ROM_DEPTH; q++) begin
      if (q == 0) begin
        rom[q] = '0;
      end else if (q >= QUARTER_TURN) begin
        rom[q] = SIN_ROM_W'(64'd1 << 30);
      end else begin
        x    = (64'(q) * PI_Q30 + 64'd180) / 64'd360;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 7; k++) begin
          term = (term * x2 + (64'd1 << 29)) >> 30;
          term = term / SERIES_DIV[k];
          if (k % 2 == 1) begin
            sum = sum - $signed(term);
          end else begin
            sum = sum + $signed(term);
          end
        end
        if (sum < 0) begin
          sum = '0;
        end
        rom[q] = SIN_ROM_W'(sum);
      end
    end
    return rom;
  endfunction

endpackage

>>> hdl/orbit_camera_position.sv
// orbit camera position: camera point on a sphere around the ship
// steps: update, angles, trig, multiply h, z, x, y, then output (a held item goes straight to output); output can stall
// one item in work at a time; shared trig unit and multiplier per step
// the input is not ready while an item is in work; a finished result waits in the output register
// reset (rst_n low, synchronous): distance 3.0, pitch 0, orbit 180 deg, last position zero
// depends on ocp_pkg and ocp_trig
module orbit_camera_position #(
  parameter int TRIG_FRACTION_BITS = ocp_pkg::TRIG_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: right_button[0], x_motion[11:1], y_motion[22:12], ship_yaw[32:23],
  //        ship_tilt[42:33], hold[43], zero pad[47:44]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  // tdata: pos_x[16:0], pos_y[33:17], pos_z[50:34], zero pad[55:51]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  // orbit_distance, unsigned Q8.8
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int F      = TRIG_FRACTION_BITS;
  localparam int TW     = F + 2;
  localparam int PROD_W = 17 + F + 1;
  localparam int RND_W  = PROD_W + 1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_UPD   = 9'b000000010,
    ST_ANG   = 9'b000000100,
    ST_TRIG  = 9'b000001000,
    ST_MUL_H = 9'b000010000,
    ST_MUL_Z = 9'b000100000,
    ST_MUL_X = 9'b001000000,
    ST_MUL_Y = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic        in_fire;
  logic        out_load;

  // control and state registers
  logic [15:0]        dist_r;
  logic signed [8:0]  pitch_r, pitch_nxt;
  logic [9:0]         orbit_r, orbit_nxt;
  logic signed [16:0] last_x_r, last_y_r, last_z_r;
  logic               out_valid_r;

  // payload registers
  logic               btn_r;
  logic signed [10:0] xm_r, ym_r;
  logic [9:0]         yaw_r, tilt_r;
  logic [9:0]         yaw_m_r, tilt_m_r;
  logic [9:0]         elev_r, az_r;
  logic [9:0]         elev_nxt, az_nxt;
  logic signed [TW-1:0] trig_r;
  logic signed [16:0] h_r;
  logic signed [16:0] out_x_r, out_y_r, out_z_r;

  // shared units
  ocp_pkg::trig_req_t   trig_req;
  logic signed [TW-1:0] trig_val;
  logic signed [16:0]   mul_a;
  logic signed [16:0]   mul_res;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_z_r, out_y_r, out_x_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = in_tdata[43] ? ST_OUT : ST_UPD;
      ST_UPD:   state_nxt = ST_ANG;
      ST_ANG:   state_nxt = ST_TRIG;
      ST_TRIG:  state_nxt = ST_MUL_H;
      ST_MUL_H: state_nxt = ST_MUL_Z;
      ST_MUL_Z: state_nxt = ST_MUL_X;
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // pitch clamp and orbit wrap
  logic signed [11:0] pitch_sum;
  logic signed [11:0] orbit_diff;
  always_comb begin
    pitch_sum  = 12'(pitch_r) + 12'(ym_r);
    orbit_diff = $signed({2'b0, orbit_r}) - 12'(xm_r);
    priority if (pitch_sum > 12'sd178) begin
      pitch_nxt = 9'(ocp_pkg::PITCH_LIMIT);
    end else if (pitch_sum < -12'sd178) begin
      pitch_nxt = -9'(ocp_pkg::PITCH_LIMIT);
    end else begin
      pitch_nxt = pitch_sum[8:0];
    end
    priority if (orbit_diff < -12'sd720) begin
      orbit_nxt = 10'(orbit_diff + 12'(2 * ocp_pkg::TURN));
    end else if (orbit_diff < 12'sd0) begin
      orbit_nxt = 10'(orbit_diff + 12'(ocp_pkg::TURN));
    end else if (orbit_diff >= 12'sd1440) begin
      orbit_nxt = 10'(orbit_diff - 12'(2 * ocp_pkg::TURN));
    end else if (orbit_diff >= 12'sd720) begin
      orbit_nxt = 10'(orbit_diff - 12'(ocp_pkg::TURN));
    end else begin
      orbit_nxt = orbit_diff[9:0];
    end
  end

  // elevation and azimuth, modulo one turn
  logic signed [11:0] elev_sum;
  logic [10:0]        az_sum;
  always_comb begin
    elev_sum = $signed({2'b0, tilt_m_r}) + 12'(ocp_pkg::ELEV_OFFSET) + 12'(pitch_r);
    az_sum   = {1'b0, orbit_r} + {1'b0, yaw_m_r};
    if (elev_sum >= 12'sd720) begin
      elev_nxt = 10'(elev_sum - 12'(ocp_pkg::TURN));
    end else begin
      elev_nxt = elev_sum[9:0];
    end
    if (az_sum >= 11'(ocp_pkg::TURN)) begin
      az_nxt = 10'(az_sum - 11'(ocp_pkg::TURN));
    end else begin
      az_nxt = az_sum[9:0];
    end
  end

  // trig request per step
  always_comb begin
    trig_req = '{angle: elev_r, cos_sel: 1'b1, negate: 1'b0};
    priority case (1'b1)
      state_r == ST_MUL_H: trig_req = '{angle: elev_r, cos_sel: 1'b0, negate: 1'b0};
      state_r == ST_MUL_Z: trig_req = '{angle: az_r,   cos_sel: 1'b0, negate: 1'b0};
      state_r == ST_MUL_X: trig_req = '{angle: az_r,   cos_sel: 1'b1, negate: 1'b1};
      default:             trig_req = '{angle: elev_r, cos_sel: 1'b1, negate: 1'b0};
    endcase
  end

  ocp_trig #(
    .TRIG_FRACTION_BITS(F)
  ) u_trig (
    .req   (trig_req),
    .value (trig_val)
  );

  // shared rounding multiplier, Q8.8 times Q(F), ties away from zero
  logic [16:0]        mul_ma;
  logic [F:0]         mul_mb;
  logic [PROD_W-1:0]  mul_prod;
  logic [RND_W-1:0]   mul_rnd;
  logic [16:0]        mul_mag;
  always_comb begin
    mul_a    = (state_r == ST_MUL_H || state_r == ST_MUL_Z) ? $signed({1'b0, dist_r}) : h_r;
    mul_ma   = mul_a[16] ? 17'(-mul_a) : 17'(mul_a);
    mul_mb   = trig_r[TW-1] ? (F+1)'(-trig_r) : trig_r[F:0];
    mul_prod = PROD_W'(mul_ma) * PROD_W'(mul_mb);
    mul_rnd  = RND_W'(mul_prod) + (RND_W'(1) << (F - 1));
    mul_mag  = mul_rnd[F+16:F];
    mul_res  = (mul_a[16] ^ trig_r[TW-1]) ? -$signed(mul_mag) : $signed(mul_mag);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dist_r      <= ocp_pkg::DIST_RESET;
      pitch_r     <= '0;
      orbit_r     <= 10'(ocp_pkg::ORBIT_RESET);
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        dist_r <= cfg_data;
      end
      if (state_r == ST_UPD && btn_r) begin
        pitch_r <= pitch_nxt;
        orbit_r <= orbit_nxt;
      end
      if (state_r == ST_MUL_Z) last_z_r <= mul_res;
      if (state_r == ST_MUL_X) last_x_r <= mul_res;
      if (state_r == ST_MUL_Y) last_y_r <= mul_res;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      btn_r  <= in_tdata[0];
      xm_r   <= in_tdata[11:1];
      ym_r   <= in_tdata[22:12];
      yaw_r  <= in_tdata[32:23];
      tilt_r <= in_tdata[42:33];
    end
    if (state_r == ST_UPD) begin
      yaw_m_r  <= (yaw_r >= 10'(ocp_pkg::TURN)) ? yaw_r - 10'(ocp_pkg::TURN) : yaw_r;
      tilt_m_r <= (tilt_r >= 10'(ocp_pkg::TURN)) ? tilt_r - 10'(ocp_pkg::TURN) : tilt_r;
    end
    if (state_r == ST_ANG) begin
      elev_r <= elev_nxt;
      az_r   <= az_nxt;
    end
    trig_r <= trig_val;
    if (state_r == ST_MUL_H) h_r <= mul_res;
    if (out_load) begin
      out_x_r <= last_x_r;
      out_y_r <= last_y_r;
      out_z_r <= last_z_r;
    end
  end

`ifndef NO_ASSERTIONS
  // a held item skips the computation
  a_hold_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata[43] |=> state_r == ST_OUT)
    else $error("held item did not go straight to output");

  // a new result carries the last computed position
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_x_r == last_x_r && out_y_r == last_y_r && out_z_r == last_z_r)
    else $error("output does not match last position");

  // pitch stays within the clamp
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    pitch_r <= 9'sd178 && pitch_r >= -9'sd178)
    else $error("pitch out of range");

  // angles in use stay below one turn
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRIG |-> orbit_r < 10'd720 && elev_r < 10'd720 && az_r < 10'd720)
    else $error("angle outside one turn");
`endif

endmodule

>>> hdl/ocp_trig.sv
// orbit camera position: sine/cosine of a half-degree angle, signed Q(F)
// depends on ocp_pkg (request struct, table builder)
module ocp_trig #(
  parameter int TRIG_FRACTION_BITS = ocp_pkg::TRIG_FRACTION_BITS
) (
  input  ocp_pkg::trig_req_t                req,
  output logic signed [TRIG_FRACTION_BITS+1:0] value
);

  localparam int F         = TRIG_FRACTION_BITS;
  localparam int RND_SHIFT = 30 - F;

  localparam ocp_pkg::sin_rom_t SIN_ROM = ocp_pkg::sin_rom_build();

  logic [10:0]                 shifted;
  logic [9:0]                  ang;
  logic [9:0]                  q;
  logic                        neg;
  logic [ocp_pkg::SIN_ROM_W-1:0] sum;
  logic [31:0]                 sum_rnd;
  logic [F:0]                  mag;

  // cosine is sine a quarter turn ahead
  always_comb begin
    shifted = {1'b0, req.angle} + 11'(ocp_pkg::QUARTER_TURN);
    if (!req.cos_sel) begin
      ang = req.angle;
    end else if (shifted >= 11'(ocp_pkg::TURN)) begin
      ang = 10'(shifted - 11'(ocp_pkg::TURN));
    end else begin
      ang = shifted[9:0];
    end
  end

  // fold onto the first quadrant
  always_comb begin
    priority if (ang <= 10'(ocp_pkg::QUARTER_TURN)) begin
      q   = ang;
      neg = 1'b0;
    end else if (ang <= 10'(ocp_pkg::HALF_TURN)) begin
      q   = 10'(ocp_pkg::HALF_TURN) - ang;
      neg = 1'b0;
    end else if (ang <= 10'(ocp_pkg::THREE_QUARTER)) begin
      q   = ang - 10'(ocp_pkg::HALF_TURN);
      neg = 1'b1;
    end else begin
      q   = 10'(ocp_pkg::TURN) - ang;
      neg = 1'b1;
    end
  end

  // table lookup and round to F fraction bits
  always_comb begin
    sum     = SIN_ROM[q[7:0]];
    sum_rnd = {1'b0, sum} + (32'd1 << (RND_SHIFT - 1));
    mag     = sum_rnd[RND_SHIFT+F:RND_SHIFT];
    if (neg ^ req.negate) begin
      value = -$signed({1'b0, mag});
    end else begin
      value = $signed({1'b0, mag});
    end
  end

endmodule
